[src/bsp_pkg.sv]
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and codes for the bounded stack with sorted push
// Request kinds, result status codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FillW   = 5;

  localparam logic [KindW-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KindW-1:0] KIND_POP   = 2'd1;
  localparam logic [KindW-1:0] KIND_SPUSH = 2'd2;

  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

  localparam logic [DataW-1:0] POP_NONE = {DataW{1'b1}};

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             push;
    logic             spush;
    logic [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

[src/bounded_stack_with_sorted_push.sv]
// ----------------------------------------------------------------------------
// bounded_stack_with_sorted_push: signed stack with push, pop, sorted push
//
// Requests arrive on in_valid_i/in_ready_o with kind_i and value_i. A push
// puts value_i on top, a pop returns the top entry, a sorted push inserts
// value_i below the lowest entry that is not less than it, moving the
// entries above up one place. Every request gives one result on
// out_valid_o/out_ready_i: popped_o (-1 unless a pop found an entry),
// status_o (done, full so push dropped, empty pop) and fill_o.
// Each entry is a cell of a chain; all cells compare and move in the same
// cycle, and the result appears in the output register on the next cycle.
// One request per cycle is sustained while the receiver takes each result.
// The insertion point ripples through the chain, one OR per cell.
// When the receiver stalls, the result stays in the output register and
// in_ready_o drops until it is taken. Reset empties the stack and the output
// register; entry contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_stack_with_sorted_push import bsp_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [DataW-1:0]   value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DataW-1:0]   popped_o,
  output logic [StatusW-1:0] status_o,
  output logic [FillW-1:0]   fill_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]    fill_q, fill_d;
  logic               out_valid_q;
  logic [DataW-1:0]   popped_q, popped_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [FillW-1:0]   fill_out_q;

  logic             accept;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  logic [DataW-1:0] entry  [DEPTH];
  logic             found  [DEPTH+1];
  logic [DataW-1:0] prev   [DEPTH];
  logic [DataW-1:0] top_val;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign full       = (fill_q == CntW'(DEPTH));
  assign empty      = (fill_q == '0);

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_bottom
      assign prev[i] = '0;
    end else begin : g_upper
      assign prev[i] = entry[i-1];
    end

    bsp_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .valid_i   (CntW'(i) < fill_q),
      .at_fill_i (CntW'(i) == fill_q),
      .prev_i    (prev[i]),
      .found_i   (found[i]),
      .entry_o   (entry[i]),
      .found_o   (found[i+1])
    );
  end

  // top entry read as an and-or over the cells
  always_comb begin
    top_val = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (fill_q == CntW'(i + 1)) begin
        top_val = top_val | entry[i];
      end
    end
  end

  always_comb begin
    ctrl.push  = 1'b0;
    ctrl.spush = 1'b0;
    ctrl.value = value_i;
    fill_d     = fill_q;
    popped_d   = POP_NONE;
    status_d   = STATUS_DONE;
    case (kind_i)
      KIND_PUSH, KIND_SPUSH: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          ctrl.push  = accept & (kind_i == KIND_PUSH);
          ctrl.spush = accept & (kind_i == KIND_SPUSH);
          fill_d     = fill_q + CntW'(1);
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          popped_d = top_val;
          fill_d   = fill_q - CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q   <= popped_d;
      status_q   <= status_d;
      fill_out_q <= FillW'(fill_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign popped_o    = popped_q;
  assign status_o    = status_q;
  assign fill_o      = fill_out_q;

endmodule

[src/bsp_cell.sv]
// ----------------------------------------------------------------------------
// bsp_cell: one stack entry
// Holds one value, compares it with the incoming request value and either
// keeps it, takes the new value or takes its lower neighbor's entry.
// ----------------------------------------------------------------------------
module bsp_cell import bsp_pkg::*; (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             valid_i,    // entry is below the fill count
  input  logic             at_fill_i,  // entry is the first free place
  input  logic [DataW-1:0] prev_i,     // entry of the cell below
  input  logic             found_i,    // insertion point lies below
  output logic [DataW-1:0] entry_o,
  output logic             found_o
);

  logic [DataW-1:0] entry_q, entry_d;
  logic             lt;
  logic             ge;

  always_comb begin
    lt      = $signed(entry_q) < $signed(ctrl_i.value);
    ge      = valid_i & ~lt;
    found_o = found_i | ge;
    entry_d = entry_q;
    if (ctrl_i.push && at_fill_i) begin
      entry_d = ctrl_i.value;
    end else if (ctrl_i.spush && (valid_i || at_fill_i)) begin
      if (found_i) begin
        entry_d = prev_i;
      end else if (ge || at_fill_i) begin
        entry_d = ctrl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
